// ===== sv/dsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsa_pkg
// Shared types and constants of the descriptor slot allocator.
// ----------------------------------------------------------------------------
package dsa_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int SLOT_W    = 10;
  localparam int COUNT_W   = 11;
  localparam int HANDLE_W  = 32;
  localparam int INDEX_W   = 16;
  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 56;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic load;
    logic fire;
  } dp_cmd_t;

endpackage

// ===== sv/dsa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsa_ctrl
// Controller that sequences item capture, execution and result hand-off.
// ----------------------------------------------------------------------------
module dsa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output dsa_pkg::dp_cmd_t  dp_cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   load, fire;

  assign in_tready  = (state_r == ST_IDLE);
  assign load       = in_tready && in_tvalid;
  assign fire       = (state_r == ST_EXEC) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign dp_cmd     = '{load: load, fire: fire};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (load) state_nxt = ST_EXEC;
      ST_EXEC: if (fire) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/dsa_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsa_datapath
// Handle stores, free-slot stacks, counters and the result register.
// ----------------------------------------------------------------------------
module dsa_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dsa_pkg::dp_cmd_t                  dp_cmd,
  input  logic [dsa_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [dsa_pkg::IN_USER_W-1:0]     in_tuser,
  input  logic                              cfg_valid,
  input  logic [dsa_pkg::COUNT_W-1:0]       cfg_data,
  output logic [dsa_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [0:0]                        out_tuser
);

  logic [dsa_pkg::HANDLE_W-1:0] tex_store [dsa_pkg::MAX_SLOTS];
  logic [dsa_pkg::HANDLE_W-1:0] buf_store [dsa_pkg::MAX_SLOTS];
  logic [dsa_pkg::SLOT_W-1:0]   tex_stack [dsa_pkg::MAX_SLOTS];
  logic [dsa_pkg::SLOT_W-1:0]   buf_stack [dsa_pkg::MAX_SLOTS];

  dsa_pkg::cmd_t                cmd_r;
  logic                         sel_r;
  logic [dsa_pkg::HANDLE_W-1:0] handle_r;
  logic [dsa_pkg::INDEX_W-1:0]  idx_r;
  logic [dsa_pkg::COUNT_W-1:0]  max_slots_r;
  logic [dsa_pkg::COUNT_W-1:0]  hw_r [2];
  logic [dsa_pkg::COUNT_W-1:0]  fd_r [2];
  logic [dsa_pkg::COUNT_W-1:0]  hw_nxt [2];
  logic [dsa_pkg::COUNT_W-1:0]  fd_nxt [2];
  logic [dsa_pkg::HANDLE_W-1:0] tex_st_q, buf_st_q;
  logic [dsa_pkg::SLOT_W-1:0]   tex_sk_q, buf_sk_q;

  logic [dsa_pkg::SLOT_W-1:0]   rd_idx;
  logic [dsa_pkg::SLOT_W-1:0]   tex_sk_ra, buf_sk_ra;

  logic [dsa_pkg::COUNT_W-1:0]  hw_sel, fd_sel, limit;
  logic [dsa_pkg::HANDLE_W-1:0] st_sel;
  logic [dsa_pkg::SLOT_W-1:0]   sk_sel;
  logic                         idx_ok;

  logic                         st_we, sk_we;
  logic [dsa_pkg::SLOT_W-1:0]   st_wa, sk_wa, sk_wd;
  logic [dsa_pkg::HANDLE_W-1:0] st_wd;

  logic                         valid_nxt, valid_r;
  logic [dsa_pkg::SLOT_W-1:0]   slot_nxt, slot_r;
  logic [dsa_pkg::HANDLE_W-1:0] hout_nxt, hout_r;
  logic [dsa_pkg::COUNT_W-1:0]  active_nxt, active_r;

  assign rd_idx    = in_tdata[dsa_pkg::HANDLE_W +: dsa_pkg::SLOT_W];
  assign tex_sk_ra = fd_r[0][dsa_pkg::SLOT_W-1:0] - dsa_pkg::SLOT_W'(1);
  assign buf_sk_ra = fd_r[1][dsa_pkg::SLOT_W-1:0] - dsa_pkg::SLOT_W'(1);

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_r    <= dsa_pkg::cmd_t'(in_tuser[1:0]);
      sel_r    <= in_tuser[2];
      handle_r <= in_tdata[dsa_pkg::HANDLE_W-1:0];
      idx_r    <= in_tdata[dsa_pkg::HANDLE_W +: dsa_pkg::INDEX_W];
      tex_st_q <= tex_store[rd_idx];
      buf_st_q <= buf_store[rd_idx];
      tex_sk_q <= tex_stack[tex_sk_ra];
      buf_sk_q <= buf_stack[buf_sk_ra];
    end
  end

  assign hw_sel = hw_r[sel_r];
  assign fd_sel = fd_r[sel_r];
  assign st_sel = sel_r ? buf_st_q : tex_st_q;
  assign sk_sel = sel_r ? buf_sk_q : tex_sk_q;
  assign limit  = (max_slots_r > dsa_pkg::COUNT_W'(dsa_pkg::MAX_SLOTS)) ?
                  dsa_pkg::COUNT_W'(dsa_pkg::MAX_SLOTS) : max_slots_r;
  assign idx_ok = idx_r < dsa_pkg::INDEX_W'(hw_sel);

  always_comb begin
    hw_nxt    = hw_r;
    fd_nxt    = fd_r;
    st_we     = 1'b0;
    st_wa     = idx_r[dsa_pkg::SLOT_W-1:0];
    st_wd     = '0;
    sk_we     = 1'b0;
    sk_wa     = fd_sel[dsa_pkg::SLOT_W-1:0];
    sk_wd     = idx_r[dsa_pkg::SLOT_W-1:0];
    valid_nxt = 1'b0;
    slot_nxt  = '0;
    hout_nxt  = '0;
    unique case (cmd_r)
      dsa_pkg::CMD_ALLOC: begin
        if (handle_r != '0) begin
          if (fd_sel != '0) begin
            fd_nxt[sel_r] = fd_sel - dsa_pkg::COUNT_W'(1);
            st_we         = 1'b1;
            st_wa         = sk_sel;
            st_wd         = handle_r;
            valid_nxt     = 1'b1;
            slot_nxt      = sk_sel;
          end else if (hw_sel < limit) begin
            hw_nxt[sel_r] = hw_sel + dsa_pkg::COUNT_W'(1);
            st_we         = 1'b1;
            st_wa         = hw_sel[dsa_pkg::SLOT_W-1:0];
            st_wd         = handle_r;
            valid_nxt     = 1'b1;
            slot_nxt      = hw_sel[dsa_pkg::SLOT_W-1:0];
          end
        end
      end
      dsa_pkg::CMD_FREE: begin
        if (idx_ok && (st_sel != '0) &&
            (fd_sel < dsa_pkg::COUNT_W'(dsa_pkg::MAX_SLOTS))) begin
          st_we         = 1'b1;
          sk_we         = 1'b1;
          fd_nxt[sel_r] = fd_sel + dsa_pkg::COUNT_W'(1);
        end
      end
      dsa_pkg::CMD_LOOKUP: begin
        if (idx_ok) hout_nxt = st_sel;
      end
      dsa_pkg::CMD_CLEAR: begin
        hw_nxt[0] = '0;
        hw_nxt[1] = '0;
        fd_nxt[0] = '0;
        fd_nxt[1] = '0;
      end
      default: ;
    endcase
    active_nxt = hw_nxt[sel_r] - fd_nxt[sel_r];
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.fire && st_we && !sel_r) tex_store[st_wa] <= st_wd;
    if (dp_cmd.fire && st_we &&  sel_r) buf_store[st_wa] <= st_wd;
    if (dp_cmd.fire && sk_we && !sel_r) tex_stack[sk_wa] <= sk_wd;
    if (dp_cmd.fire && sk_we &&  sel_r) buf_stack[sk_wa] <= sk_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r[0]     <= '0;
      hw_r[1]     <= '0;
      fd_r[0]     <= '0;
      fd_r[1]     <= '0;
      max_slots_r <= dsa_pkg::COUNT_W'(dsa_pkg::MAX_SLOTS);
    end else begin
      if (dp_cmd.fire) begin
        hw_r <= hw_nxt;
        fd_r <= fd_nxt;
      end
      if (cfg_valid) max_slots_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.fire) begin
      valid_r  <= valid_nxt;
      slot_r   <= slot_nxt;
      hout_r   <= hout_nxt;
      active_r <= active_nxt;
    end
  end

  assign out_tuser = valid_r;
  assign out_tdata = {3'b000, active_r, hout_r, slot_r};

endmodule

// ===== sv/descriptor_slot_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// descriptor_slot_allocator_core
// Two-table slot allocator with handle stores and LIFO free-slot stacks.
// ----------------------------------------------------------------------------
// Items arrive on the in_ channel and carry a command, a table select, a
// handle and a slot index. Each item yields exactly one result on the out_
// channel with the allocate outcome, the looked-up handle and the active
// count of the selected table after the item has acted.
// An item's store entry and stack top are read when the item is accepted;
// they are written and its result registered when it executes, which waits
// for a free output register. No new item is taken until the item executes.
// The max_slots register is written on the cfg_ channel, which is always
// ready and should only be used while no item is in flight.
// Reset clears both tables and sets max_slots to 1024; no clearing pass is
// needed. When the receiver stalls, the finished result waits in the output
// register while the next item is taken and read; that item then holds until
// the output register is free, and in_tready stays low meanwhile.
// ----------------------------------------------------------------------------
module descriptor_slot_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // handle[31:0], slot_index[47:32]
  input  logic [2:0]  in_tuser,   // command[1:0], table_select[2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // slot_out[9:0], handle_out[41:10],
                                  // active_count[52:42], zero[55:53]
  output logic [0:0]  out_tuser,  // slot_valid[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);

  dsa_pkg::dp_cmd_t dp_cmd;

  assign cfg_ready = 1'b1;

  dsa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .dp_cmd     (dp_cmd)
  );

  dsa_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .dp_cmd    (dp_cmd),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  a_one_item_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an item was in flight");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[52:42] <= 11'd1024))
    else $error("active count out of range");

  a_alloc_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata[52:42] != 11'd0))
    else $error("successful allocate with zero active count");

  a_slot_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata[9:0] == 10'd0))
    else $error("slot reported without a successful allocate");

  a_exec_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.fire |-> !in_tready)
    else $error("execution while idle");

endmodule
